@@ rtl/lpw_pkg.sv @@
package lpw_pkg;

   localparam int COORD_W = 10;
   localparam int INDEX_W = 20;
   // Cross products (row offset * dx, dy * column offset) plus sign and margin.
   localparam int PROD_W = 2 * COORD_W + 2;

   localparam int SCREEN_WIDTH = 1024;
   localparam logic [INDEX_W-1:0] ROW_STEP = INDEX_W'(SCREEN_WIDTH);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      MODE_VERTICAL = 2'd0,
      MODE_HORIZONTAL = 2'd1,
      MODE_RISING = 2'd2,
      MODE_FALLING = 2'd3
   } mode_type;

   typedef struct packed {
      logic func;
      logic [COORD_W-1:0] end_a_x;
      logic [COORD_W-1:0] end_a_y;
      logic [COORD_W-1:0] end_b_x;
      logic [COORD_W-1:0] end_b_y;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [INDEX_W-1:0] pixel_index;
      logic last_pixel;
   } pixel_type;

   typedef struct packed {
      logic valid;
      pixel_type pixel;
   } result_type;

endpackage

@@ rtl/lpw_walker.sv @@
module lpw_walker
   import lpw_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic step_en,
   input item_type item,
   output result_type result
);

   logic [COORD_W-1:0] walk_x_ff, walk_x_in;
   logic [COORD_W-1:0] walk_y_ff, walk_y_in;
   logic [COORD_W-1:0] left_x_ff, left_x_in;
   logic [COORD_W-1:0] left_y_ff, left_y_in;
   logic [COORD_W-1:0] right_x_ff, right_x_in;
   logic [COORD_W-1:0] right_y_ff, right_y_in;
   logic [COORD_W-1:0] dx_ff, dx_in;
   logic signed [COORD_W:0] dy_ff, dy_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   // Running cross products: lhs = (y - left_y) * dx, rhs = dy * (x - left_x)
   logic signed [PROD_W-1:0] lhs_ff, lhs_in;
   logic signed [PROD_W-1:0] rhs_ff, rhs_in;
   mode_type mode_ff, mode_in;
   logic active_ff, active_in;

   logic [COORD_W-1:0] sel_lx, sel_ly, sel_rx, sel_ry;
   logic signed [PROD_W-1:0] dx_ext, dy_ext;
   logic on_line;
   logic last;

   assign dx_ext = PROD_W'(signed'({1'b0, dx_ff}));
   assign dy_ext = PROD_W'(dy_ff);
   assign on_line = (mode_ff == MODE_RISING) ? (lhs_ff <= rhs_ff) : (lhs_ff >= rhs_ff);

   always_comb begin
      if (item.end_b_x >= item.end_a_x) begin
         sel_lx = item.end_a_x;
         sel_ly = item.end_a_y;
         sel_rx = item.end_b_x;
         sel_ry = item.end_b_y;
      end else begin
         sel_lx = item.end_b_x;
         sel_ly = item.end_b_y;
         sel_rx = item.end_a_x;
         sel_ry = item.end_a_y;
      end
   end

   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      left_x_in = left_x_ff;
      left_y_in = left_y_ff;
      right_x_in = right_x_ff;
      right_y_in = right_y_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      index_in = index_ff;
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      mode_in = mode_ff;
      active_in = active_ff;
      last = 1'b0;
      result.valid = 1'b0;

      if (step_en && item.func == FUNC_LOAD) begin
         left_x_in = sel_lx;
         left_y_in = sel_ly;
         right_x_in = sel_rx;
         right_y_in = sel_ry;
         dx_in = sel_rx - sel_lx;
         dy_in = signed'({1'b0, sel_ry}) - signed'({1'b0, sel_ly});
         walk_x_in = sel_lx;
         walk_y_in = sel_ly;
         index_in = INDEX_W'(sel_ly) * ROW_STEP + INDEX_W'(sel_lx);
         lhs_in = '0;
         rhs_in = '0;
         active_in = 1'b1;
         if (sel_lx == sel_rx) begin
            mode_in = MODE_VERTICAL;
         end else if (sel_ly == sel_ry) begin
            mode_in = MODE_HORIZONTAL;
         end else if (sel_ry > sel_ly) begin
            mode_in = MODE_RISING;
         end else begin
            mode_in = MODE_FALLING;
         end
      end else if (step_en && active_ff) begin
         case (mode_ff)
            MODE_VERTICAL: begin
               last = (walk_y_ff == right_y_ff);
               result.valid = 1'b1;
               if (last) begin
                  active_in = 1'b0;
               end else if (right_y_ff > walk_y_ff) begin
                  walk_y_in = walk_y_ff + 1'b1;
                  index_in = index_ff + ROW_STEP;
               end else begin
                  walk_y_in = walk_y_ff - 1'b1;
                  index_in = index_ff - ROW_STEP;
               end
            end
            MODE_HORIZONTAL: begin
               last = (walk_x_ff == right_x_ff);
               result.valid = 1'b1;
               if (last) begin
                  active_in = 1'b0;
               end else begin
                  walk_x_in = walk_x_ff + 1'b1;
                  index_in = index_ff + INDEX_W'(1);
               end
            end
            default: begin
               if (on_line) begin
                  last = (walk_x_ff == right_x_ff) && (walk_y_ff == right_y_ff);
                  result.valid = 1'b1;
                  if (last) begin
                     active_in = 1'b0;
                  end else if (mode_ff == MODE_RISING) begin
                     walk_y_in = walk_y_ff + 1'b1;
                     lhs_in = lhs_ff + dx_ext;
                     index_in = index_ff + ROW_STEP;
                  end else begin
                     walk_y_in = walk_y_ff - 1'b1;
                     lhs_in = lhs_ff - dx_ext;
                     index_in = index_ff - ROW_STEP;
                  end
               end else if (walk_x_ff == right_x_ff) begin
                  active_in = 1'b0;
               end else begin
                  // off the ideal line: next column, no pixel
                  walk_x_in = walk_x_ff + 1'b1;
                  rhs_in = rhs_ff + dy_ext;
                  index_in = index_ff + INDEX_W'(1);
               end
            end
         endcase
      end

      result.pixel.pixel_x = walk_x_ff;
      result.pixel.pixel_y = walk_y_ff;
      result.pixel.pixel_index = index_ff;
      result.pixel.last_pixel = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         left_x_ff <= '0;
         left_y_ff <= '0;
         right_x_ff <= '0;
         right_y_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         index_ff <= '0;
         lhs_ff <= '0;
         rhs_ff <= '0;
         mode_ff <= MODE_VERTICAL;
         active_ff <= 1'b0;
      end else begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         left_x_ff <= left_x_in;
         left_y_ff <= left_y_in;
         right_x_ff <= right_x_in;
         right_y_ff <= right_y_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         index_ff <= index_in;
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
         mode_ff <= mode_in;
         active_ff <= active_in;
      end
   end

`ifndef ASSERT_OFF
   logic signed [PROD_W-1:0] chk_row_ofs, chk_col_ofs;
   assign chk_row_ofs = PROD_W'(signed'({1'b0, walk_y_ff})) - PROD_W'(signed'({1'b0, left_y_ff}));
   assign chk_col_ofs = PROD_W'(signed'({1'b0, walk_x_ff})) - PROD_W'(signed'({1'b0, left_x_ff}));

   // Far endpoint ends the line.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.pixel.last_pixel |=> !active_ff)
      else $error("line still active after last pixel");

   // Walk never runs past the right endpoint column.
   a_walk_in_span: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (walk_x_ff >= left_x_ff) && (walk_x_ff <= right_x_ff))
      else $error("walk column outside the line span");

   // Incremental cross products track the exact products.
   a_lhs_exact: assert property (@(posedge clock) disable iff (reset)
      active_ff && (mode_ff == MODE_RISING || mode_ff == MODE_FALLING)
      |-> lhs_ff == chk_row_ofs * dx_ext)
      else $error("row cross product drifted");

   a_rhs_exact: assert property (@(posedge clock) disable iff (reset)
      active_ff && (mode_ff == MODE_RISING || mode_ff == MODE_FALLING)
      |-> rhs_ff == dy_ext * chk_col_ofs)
      else $error("column cross product drifted");
`endif

endmodule

@@ rtl/line_pixel_walker_core.sv @@
// Line pixel walker.
// req channel: one transfer per command. tuser = func: load (two endpoints, no
// result) or advance (one walk step, zero or one pixel). The walk state lives
// in the block between commands, so a new load simply replaces the old line.
// rsp channel: one transfer per emitted pixel; tlast marks the far endpoint,
// after which advances give nothing until the next load.
// An advance is taken into the command register; its pixel is registered onto
// rsp. Throughput: one command per cycle unless rsp stalls. Step logic is a
// single pass between the command and result registers; the frame buffer index
// and the slope cross products are running sums, so a step is a few adds and
// one signed compare. Only a load does a row * screen-width multiply.
// Stall: while rsp_tready is low and a pixel is held, the held command waits
// in the command register and req_tready drops; nothing is lost or repeated.
// Reset: synchronous; clears both registers' valid flags and the walk state
// (idle, vertical mode, all coordinates zero).
module line_pixel_walker_core
   import lpw_pkg::*;
(
   input logic clock,
   input logic reset,

   input logic req_tvalid,
   output logic req_tready,
   input logic [39:0] req_tdata,   // end_a_x[9:0], end_a_y[19:10], end_b_x[29:20], end_b_y[39:30]
   input logic req_tuser,          // func: 0 load, 1 advance

   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [39:0] rsp_tdata,  // pixel_x[9:0], pixel_y[19:10], pixel_index[39:20]
   output logic rsp_tlast          // last_pixel
);

   item_type in_item_ff;
   logic in_valid_ff, in_valid_in;
   pixel_type rsp_pixel_ff;
   logic rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic step_go;
   result_type step_res;
   item_type req_item;

   assign req_item.func = req_tuser;
   assign req_item.end_a_x = req_tdata[9:0];
   assign req_item.end_a_y = req_tdata[19:10];
   assign req_item.end_b_x = req_tdata[29:20];
   assign req_item.end_b_y = req_tdata[39:30];

   // held command executes when the result slot is free or draining
   assign step_go = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign req_fire = req_tvalid && req_tready;

   assign in_valid_in = req_fire || (in_valid_ff && !step_go);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_go) begin
         rsp_valid_in = step_res.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lpw_walker u_walker (
      .clock(clock),
      .reset(reset),
      .step_en(step_go),
      .item(in_item_ff),
      .result(step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (step_go) begin
         rsp_pixel_ff <= step_res.pixel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_pixel_ff.pixel_index, rsp_pixel_ff.pixel_y, rsp_pixel_ff.pixel_x};
   assign rsp_tlast = rsp_pixel_ff.last_pixel;

endmodule
